// File: rtl/mtfq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Move-to-front queue package
// Field widths, command and error codes and microcode word layout shared by
// the sequencer and the datapath, and the microprogram read-only table.
// ----------------------------------------------------------------------------
package mtfq_pkg;

    // Fixed field widths of the command and result words.
    localparam int CMD_W  = 2;
    localparam int DATA_W = 32;
    localparam int POS_W  = 5;
    localparam int CNT_W  = 5;
    localparam int ERR_W  = 2;

    // Defaults for the top-level parameters.
    localparam int DEF_DEPTH      = 16;
    localparam int DEF_DATA_WIDTH = 32;

    typedef enum logic [CMD_W-1:0] {
        CMD_ENQ = 2'd0,
        CMD_DEQ = 2'd1,
        CMD_REV = 2'd2,
        CMD_MTF = 2'd3
    } t_cmd;

    typedef enum logic [ERR_W-1:0] {
        ERR_OK    = 2'd0,
        ERR_EMPTY = 2'd1,
        ERR_FULL  = 2'd2,
        ERR_POS   = 2'd3
    } t_err;

    // Microprogram addresses.
    typedef logic [3:0] t_upc;
    localparam t_upc UA_IDLE = 4'd0;
    localparam t_upc UA_DISP = 4'd1;
    localparam t_upc UA_ENQ  = 4'd2;
    localparam t_upc UA_DEQ  = 4'd3;
    localparam t_upc UA_DEQ2 = 4'd4;
    localparam t_upc UA_REV  = 4'd5;
    localparam t_upc UA_MTF0 = 4'd6;
    localparam t_upc UA_MTFL = 4'd7;
    localparam t_upc UA_MTFE = 4'd8;
    localparam t_upc UA_RES  = 4'd9;

    typedef enum logic [2:0] {
        JMP_GOTO     = 3'd0,
        JMP_WAIT_IN  = 3'd1,
        JMP_WAIT_OUT = 3'd2,
        JMP_LOOP     = 3'd3,
        JMP_DISPATCH = 3'd4
    } t_jmp;

    typedef enum logic [1:0] {
        WA_ZERO = 2'd0,
        WA_OCC  = 2'd1,
        WA_I    = 2'd2
    } t_wa;

    typedef enum logic {
        RA_ZERO = 1'b0,
        RA_I1   = 1'b1
    } t_ra;

    typedef enum logic [1:0] {
        IOP_HOLD = 2'd0,
        IOP_CLR  = 2'd1,
        IOP_INC  = 2'd2
    } t_iop;

    typedef enum logic [1:0] {
        HOP_HOLD = 2'd0,
        HOP_DEQ  = 2'd1,
        HOP_REV  = 2'd2
    } t_hop;

    typedef enum logic [1:0] {
        OOP_HOLD = 2'd0,
        OOP_INC  = 2'd1,
        OOP_DEC  = 2'd2
    } t_oop;

    // One control word of the microprogram.
    typedef struct packed {
        logic in_ready;
        logic res_init;
        logic res_load;
        logic dout_cap;
        t_wa  wa_sel;
        t_ra  ra_sel;
        logic wr_en;
        logic wd_carry;
        logic carry_cap;
        t_iop i_op;
        t_hop head_op;
        t_oop occ_op;
        logic rev_flip;
        t_jmp jmp;
        t_upc target;
    } t_uop;

    // Status returned from the datapath to the sequencer.
    typedef struct packed {
        logic in_valid;
        logic out_free;
        logic err;
        t_cmd cmd;
        logic last;
    } t_stat;

    // Microprogram table.
    function automatic t_uop uop_rom(input t_upc a);
        t_uop w;
        w = '0;
        unique case (a)
            UA_IDLE: begin
                w.in_ready = 1'b1;
                w.jmp      = JMP_WAIT_IN;
                w.target   = UA_DISP;
            end
            UA_DISP: begin
                w.res_init = 1'b1;
                w.i_op     = IOP_CLR;
                w.jmp      = JMP_DISPATCH;
            end
            UA_ENQ: begin
                w.wa_sel = WA_OCC;
                w.wr_en  = 1'b1;
                w.occ_op = OOP_INC;
                w.target = UA_RES;
            end
            UA_DEQ: begin
                w.ra_sel = RA_ZERO;
                w.target = UA_DEQ2;
            end
            UA_DEQ2: begin
                w.dout_cap = 1'b1;
                w.head_op  = HOP_DEQ;
                w.occ_op   = OOP_DEC;
                w.target   = UA_RES;
            end
            UA_REV: begin
                w.head_op  = HOP_REV;
                w.rev_flip = 1'b1;
                w.target   = UA_RES;
            end
            UA_MTF0: begin
                w.ra_sel = RA_ZERO;
                w.target = UA_MTFL;
            end
            UA_MTFL: begin
                w.wa_sel    = WA_I;
                w.wr_en     = 1'b1;
                w.wd_carry  = 1'b1;
                w.carry_cap = 1'b1;
                w.ra_sel    = RA_I1;
                w.i_op      = IOP_INC;
                w.jmp       = JMP_LOOP;
                w.target    = UA_MTFE;
            end
            UA_MTFE: begin
                w.wa_sel   = WA_ZERO;
                w.wr_en    = 1'b1;
                w.wd_carry = 1'b1;
                w.target   = UA_RES;
            end
            UA_RES: begin
                w.res_load = 1'b1;
                w.jmp      = JMP_WAIT_OUT;
                w.target   = UA_IDLE;
            end
            default: begin
                w.target = UA_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage
`default_nettype wire

// File: rtl/mtfq_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Move-to-front queue command channel
// Valid/ready channel carrying one command word.
// ----------------------------------------------------------------------------
interface mtfq_in_if;
    import mtfq_pkg::*;

    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic [DATA_W-1:0] data_in;
    logic [POS_W-1:0]  position;

    modport source (output valid, command, data_in, position, input ready);
    modport sink   (input valid, command, data_in, position, output ready);
endinterface
`default_nettype wire

// File: rtl/mtfq_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Move-to-front queue result channel
// Valid/ready channel carrying one result word.
// ----------------------------------------------------------------------------
interface mtfq_out_if;
    import mtfq_pkg::*;

    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] data_out;
    logic              data_valid;
    logic [CNT_W-1:0]  entry_count;
    logic              is_empty;
    logic [ERR_W-1:0]  error_code;

    modport source (output valid, data_out, data_valid, entry_count, is_empty,
                    error_code, input ready);
    modport sink   (input valid, data_out, data_valid, entry_count, is_empty,
                    error_code, output ready);
endinterface
`default_nettype wire

// File: rtl/mtfq_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module mtfq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write and registered read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

// File: rtl/mtfq_useq.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Move-to-front queue microsequencer
// Step counter, microprogram table and jump logic.
// ----------------------------------------------------------------------------
module mtfq_useq (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire mtfq_pkg::t_stat i_stat,
    output mtfq_pkg::t_uop      o_uop
);
    import mtfq_pkg::*;

    t_upc r_upc;
    t_upc n_upc;
    t_uop w_uop;

    // Current control word.
    always_comb begin
        w_uop = uop_rom(r_upc);
    end

    assign o_uop = w_uop;

    // Next step address.
    always_comb begin
        n_upc = r_upc;
        unique case (w_uop.jmp)
            JMP_GOTO:     n_upc = w_uop.target;
            JMP_WAIT_IN:  n_upc = i_stat.in_valid ? w_uop.target : r_upc;
            JMP_WAIT_OUT: n_upc = i_stat.out_free ? w_uop.target : r_upc;
            JMP_LOOP:     n_upc = i_stat.last ? w_uop.target : r_upc;
            JMP_DISPATCH: begin
                if (i_stat.err) begin
                    n_upc = UA_RES;
                end else begin
                    unique case (i_stat.cmd)
                        CMD_ENQ: n_upc = UA_ENQ;
                        CMD_DEQ: n_upc = UA_DEQ;
                        CMD_REV: n_upc = UA_REV;
                        CMD_MTF: n_upc = UA_MTF0;
                        default: n_upc = UA_RES;
                    endcase
                end
            end
            default:      n_upc = UA_IDLE;
        endcase
    end

    // Step counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= UA_IDLE;
        end else begin
            r_upc <= n_upc;
        end
    end

endmodule
`default_nettype wire

// File: rtl/mtfq_dpath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Move-to-front queue datapath
// Circular entry store, head, count and direction registers, the move
// carry register, command latch and result register, all driven by the
// current control word.
// ----------------------------------------------------------------------------
module mtfq_dpath #(
    parameter int DEPTH      = mtfq_pkg::DEF_DEPTH,
    parameter int DATA_WIDTH = mtfq_pkg::DEF_DATA_WIDTH
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire mtfq_pkg::t_uop i_uop,
    output mtfq_pkg::t_stat     o_stat,
    mtfq_in_if.sink             i_cmd,
    mtfq_out_if.source          o_res
);
    import mtfq_pkg::*;

    localparam int IW = $clog2(DEPTH);
    localparam int OW = $clog2(DEPTH + 1);
    localparam int SW = (DATA_WIDTH < DATA_W) ? DATA_WIDTH : DATA_W;
    localparam int CW = (OW > POS_W) ? OW : POS_W;

    // Physical index of a logical position counted from the head.
    function automatic logic [IW-1:0] phys(input logic [IW-1:0] h,
                                           input logic [IW-1:0] p,
                                           input logic          rv);
        logic [IW:0] s;
        logic [IW:0] dep;
        dep = (IW+1)'(DEPTH);
        if (!rv) begin
            s = {1'b0, h} + {1'b0, p};
            if (s >= dep) begin
                s = s - dep;
            end
        end else if (h >= p) begin
            s = {1'b0, h} - {1'b0, p};
        end else begin
            s = {1'b0, h} + dep - {1'b0, p};
        end
        return s[IW-1:0];
    endfunction

    logic [IW-1:0] r_head, n_head;
    logic [OW-1:0] r_occ, n_occ;
    logic          r_rev, n_rev;
    logic [IW-1:0] r_i, n_i;
    logic [SW-1:0] r_carry;

    t_cmd          r_cmd;
    logic [SW-1:0] r_din;
    logic [POS_W-1:0] r_pos;

    logic [SW-1:0] r_dout;
    logic          r_dvalid;
    t_err          r_err;

    logic              r_ovalid;
    logic [DATA_W-1:0] r_odata;
    logic              r_odv;
    logic [CNT_W-1:0]  r_ocnt;
    logic              r_oempty;
    t_err              r_oerr;

    logic          w_accept;
    logic          w_out_free;
    t_err          w_err;
    logic          w_last;
    logic [IW-1:0] w_occ_idx;
    logic [IW-1:0] w_occ_m1;
    logic [IW-1:0] w_waddr;
    logic [IW-1:0] w_raddr;
    logic [SW-1:0] w_wdata;
    logic [SW-1:0] w_rdata;

    assign w_accept   = i_cmd.valid && i_cmd.ready;
    assign w_out_free = !r_ovalid || o_res.ready;
    assign w_occ_idx  = IW'(r_occ);
    assign w_occ_m1   = IW'(r_occ - OW'(1));
    assign w_last     = (CW'(r_i) == (CW'(r_pos) - CW'(1)));

    // Error check on the latched command against the current state.
    always_comb begin
        w_err = ERR_OK;
        unique case (r_cmd)
            CMD_ENQ: if (CW'(r_occ) >= CW'(DEPTH)) w_err = ERR_FULL;
            CMD_DEQ: if (r_occ == '0) w_err = ERR_EMPTY;
            CMD_MTF: begin
                if ((r_pos == '0) || (CW'(r_pos) > CW'(r_occ))) begin
                    w_err = ERR_POS;
                end
            end
            default: w_err = ERR_OK;
        endcase
    end

    assign o_stat.in_valid = i_cmd.valid;
    assign o_stat.out_free = w_out_free;
    assign o_stat.err      = (w_err != ERR_OK);
    assign o_stat.cmd      = r_cmd;
    assign o_stat.last     = w_last;

    assign i_cmd.ready = i_uop.in_ready;

    // Entry store addressing.
    always_comb begin
        unique case (i_uop.wa_sel)
            WA_OCC:  w_waddr = phys(r_head, w_occ_idx, r_rev);
            WA_I:    w_waddr = phys(r_head, r_i, r_rev);
            default: w_waddr = r_head;
        endcase
        unique case (i_uop.ra_sel)
            RA_I1:   w_raddr = phys(r_head, r_i + IW'(1), r_rev);
            default: w_raddr = r_head;
        endcase
        w_wdata = i_uop.wd_carry ? r_carry : r_din;
    end

    mtfq_ram #(
        .WIDTH (SW),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_uop.wr_en),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Next values of the queue state.
    always_comb begin
        n_head = r_head;
        n_occ  = r_occ;
        n_rev  = r_rev ^ i_uop.rev_flip;
        n_i    = r_i;
        unique case (i_uop.head_op)
            HOP_DEQ: n_head = phys(r_head, IW'(1), r_rev);
            HOP_REV: if (r_occ != '0) n_head = phys(r_head, w_occ_m1, r_rev);
            default: n_head = r_head;
        endcase
        unique case (i_uop.occ_op)
            OOP_INC: n_occ = r_occ + OW'(1);
            OOP_DEC: n_occ = r_occ - OW'(1);
            default: n_occ = r_occ;
        endcase
        unique case (i_uop.i_op)
            IOP_CLR: n_i = '0;
            IOP_INC: n_i = r_i + IW'(1);
            default: n_i = r_i;
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head   <= '0;
            r_occ    <= '0;
            r_rev    <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_head <= n_head;
            r_occ  <= n_occ;
            r_rev  <= n_rev;
            if (i_uop.res_load && w_out_free) begin
                r_ovalid <= 1'b1;
            end else if (o_res.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Payload registers: command latch, move carry and result word.
    always_ff @(posedge i_clk) begin
        r_i <= n_i;
        if (w_accept) begin
            r_cmd <= t_cmd'(i_cmd.command);
            r_din <= i_cmd.data_in[SW-1:0];
            r_pos <= i_cmd.position;
        end
        if (i_uop.carry_cap) begin
            r_carry <= w_rdata;
        end
        if (i_uop.res_init) begin
            r_dout   <= '0;
            r_dvalid <= 1'b0;
            r_err    <= w_err;
        end else if (i_uop.dout_cap) begin
            r_dout   <= w_rdata;
            r_dvalid <= 1'b1;
        end
        if (i_uop.res_load && w_out_free) begin
            r_odata  <= DATA_W'(r_dout);
            r_odv    <= r_dvalid;
            r_ocnt   <= CNT_W'(r_occ);
            r_oempty <= (r_occ == '0);
            r_oerr   <= r_err;
        end
    end

    assign o_res.valid       = r_ovalid;
    assign o_res.data_out    = r_odata;
    assign o_res.data_valid  = r_odv;
    assign o_res.entry_count = r_ocnt;
    assign o_res.is_empty    = r_oempty;
    assign o_res.error_code  = r_oerr;

endmodule
`default_nettype wire

// File: rtl/move_to_front_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Move-to-front queue
// Bounded ordered queue with enqueue, dequeue, reverse and move-to-front,
// run by a microprogrammed sequencer over a single-port-pair entry store.
// ----------------------------------------------------------------------------
// Usage:
// Commands arrive as words on i_cmd (command, data_in, position); each
// command gives exactly one result word on o_res (data_out, data_valid,
// entry_count, is_empty, error_code). Commands are handled one at a time:
// i_cmd.ready is high only while the sequencer waits for a command.
// After acceptance the sequencer checks the command and dispatches it; an
// erroneous command goes straight to the result step. The next command is
// accepted only once the result has been loaded into the output register.
// Move-to-front shifts one entry back per cycle through the entry store's
// single read and single write port.
// The result sits in an output register; the sequencer may load the next
// result as soon as that register is taken. While the receiver stalls, the
// sequencer holds in its result step and takes no new command.
// Reset (synchronous, active low) empties the queue, clears the direction
// and drops any pending result; the store contents need no clearing.
// ----------------------------------------------------------------------------
module move_to_front_queue #(
    parameter int DEPTH      = mtfq_pkg::DEF_DEPTH,
    parameter int DATA_WIDTH = mtfq_pkg::DEF_DATA_WIDTH
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    mtfq_in_if.sink    i_cmd,
    mtfq_out_if.source o_res
);
    import mtfq_pkg::*;

    t_uop  w_uop;
    t_stat w_stat;

    // Microsequencer.
    mtfq_useq u_useq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (w_stat),
        .o_uop   (w_uop)
    );

    // Datapath.
    mtfq_dpath #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dpath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_uop   (w_uop),
        .o_stat  (w_stat),
        .i_cmd   (i_cmd),
        .o_res   (o_res)
    );

`ifndef SYNTHESIS
    // One command at a time: ready drops after an acceptance.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.valid && i_cmd.ready) |=> !i_cmd.ready)
        else $error("command accepted while another is in progress");

    // A dequeued word is only reported for a successful command.
    a_data_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.data_valid) |-> (o_res.error_code == ERR_OK))
        else $error("data word reported with an error code");

    // Reset drops any pending result.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_res.valid)
        else $error("result valid after reset");
`endif

endmodule
`default_nettype wire
